// ===== sv/header_delimited_command_framer_assert.svh =====
// Assertion helpers for the command framer.
// Every assertion is clocked on the rising edge and is switched off while in reset.
`ifndef HEADER_DELIMITED_COMMAND_FRAMER_ASSERT_SVH
`define HEADER_DELIMITED_COMMAND_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define HDCF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hdcf assertion failed");
// cond must never be true out of reset
`define HDCF_NEVER(name, clk, rst_n, cond) \
  `HDCF_ASSERT(name, clk, rst_n, !(cond))
`else
`define HDCF_ASSERT(name, clk, rst_n, prop)
`define HDCF_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ===== sv/hdcf_pkg.sv =====
package hdcf_pkg;

  // command buffer
  localparam int BUF_DEPTH = 20;
  localparam int IDX_W     = $clog2(BUF_DEPTH);

  // queue between the front and back parts
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // framing characters
  localparam logic [7:0] CH_O  = 8'h4F;
  localparam logic [7:0] CH_R  = 8'h52;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // result kinds
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  // one classified input word, passed from front to back
  typedef struct packed {
    logic [7:0]       data;   // received byte
    logic             store;  // byte goes into the command buffer
    logic [IDX_W-1:0] idx;    // buffer slot, also last slot of a completed command
    logic             done;   // command completes with this byte
  } hdcf_entry_t;

endpackage

// ===== sv/hdcf_in_if.sv =====
interface hdcf_in_if;
  import hdcf_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/hdcf_out_if.sv =====
interface hdcf_out_if;
  import hdcf_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_kind;
  logic       out_last;

  modport source (output valid, output out_byte, output out_kind, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_kind, input out_last,
                  output ready);
endinterface

// ===== sv/header_delimited_command_framer.sv =====
// Command framer for a received byte stream.
// rx_i carries one received byte per word (valid/ready); tx_o returns words of
// out_byte, out_kind (echo or command byte) and out_last.
// Every byte is echoed. After the header "ORD" the following bytes are
// buffered (up to BUF_DEPTH); a CR followed by a stored LF completes the
// command, and its buffered bytes follow the echo, one per cycle while
// tx_o.ready is high, with out_last on the final one. A full buffer is
// dropped silently. An accepted byte is written into the queue, then
// popped into the output register, where its echo becomes valid.
// Output: one word per cycle from the output register while tx_o.ready is
// high; a byte yields one echo word, or 1 + count words when it completes a
// count-byte command (at most 21). The front part classifies one byte per
// cycle into a four-entry queue while it has room; the back part drains it.
// Reset: framing state idle, queue and output empty; buffer contents are
// left as they are and are only read after being written.
// Receiver stall: the output word holds, the queue fills and rx_i.ready
// drops once four bytes are waiting.
module header_delimited_command_framer
  import hdcf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  hdcf_in_if.sink     rx_i,
  hdcf_out_if.source  tx_o
);

  logic        push_valid, push_ready;
  hdcf_entry_t push_entry;
  logic        pop_valid, pop_ready;
  hdcf_entry_t pop_entry;

  hdcf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  hdcf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  hdcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .tx_o        (tx_o)
  );

endmodule

// ===== sv/hdcf_queue.sv =====
`include "header_delimited_command_framer_assert.svh"

module hdcf_queue
  import hdcf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  hdcf_entry_t push_entry_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output hdcf_entry_t pop_entry_o
);

  hdcf_entry_t       store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = store_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // pointers and fill level
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_entry_i;
    end
  end

  `HDCF_NEVER(a_queue_overfill, clk_i, rst_ni, cnt_q > QCNT_W'(QUEUE_DEPTH))
  `HDCF_ASSERT(a_queue_ptr_gap, clk_i, rst_ni, (cnt_q == QCNT_W'(QUEUE_DEPTH)) || (cnt_q == '0) || (wr_ptr_q != rd_ptr_q))

endmodule

// ===== sv/hdcf_front.sv =====
`include "header_delimited_command_framer_assert.svh"

module hdcf_front
  import hdcf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  hdcf_in_if.sink      rx_i,
  output logic         push_valid_o,
  input  logic         push_ready_i,
  output hdcf_entry_t  push_entry_o
);

  localparam logic [1:0] HDR_IDLE    = 2'd0;
  localparam logic [1:0] HDR_SAW_O   = 2'd1;
  localparam logic [1:0] HDR_SAW_OR  = 2'd2;
  localparam logic [1:0] HDR_COLLECT = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUF_DEPTH - 1);

  logic [1:0]       hdr_q, hdr_d, hdr_mid;
  logic             tail_q, tail_d;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [7:0]       b;
  logic             collect, done, ovf, clr, accept;

  assign b            = rx_i.rx_byte;
  assign rx_i.ready   = push_ready_i;
  assign push_valid_o = rx_i.valid;
  assign accept       = rx_i.valid && push_ready_i;

  // classify the word against the current framing state
  assign collect = (hdr_q == HDR_COLLECT);
  assign done    = collect && tail_q && (b == CH_LF);
  assign ovf     = collect && (wr_idx_q == LAST_IDX);
  assign clr     = done || ovf;

  assign push_entry_o.data  = b;
  assign push_entry_o.store = collect;
  assign push_entry_o.idx   = wr_idx_q;
  assign push_entry_o.done  = done;

  // next framing state
  always_comb begin
    // a stored byte other than CR always ends a pending tail, by completion or by clearing
    tail_d   = (b == CH_CR) || (tail_q && !collect);
    wr_idx_d = clr ? '0 : (collect ? wr_idx_q + IDX_W'(1) : wr_idx_q);
    hdr_mid  = clr ? HDR_IDLE : hdr_q;
    case (hdr_mid)
      HDR_SAW_OR:  hdr_d = (b == CH_D) ? HDR_COLLECT : HDR_IDLE;
      HDR_SAW_O:   hdr_d = (b == CH_R) ? HDR_SAW_OR : HDR_IDLE;
      HDR_COLLECT: hdr_d = HDR_COLLECT;
      default:     hdr_d = HDR_IDLE;
    endcase
    // the same byte may open a new header
    if ((b == CH_O) && (hdr_d == HDR_IDLE)) begin
      hdr_d = HDR_SAW_O;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q    <= HDR_IDLE;
      tail_q   <= 1'b0;
      wr_idx_q <= '0;
    end else if (accept) begin
      hdr_q    <= hdr_d;
      tail_q   <= tail_d;
      wr_idx_q <= wr_idx_d;
    end
  end

  `HDCF_NEVER(a_idx_in_range, clk_i, rst_ni, wr_idx_q > LAST_IDX)
  `HDCF_ASSERT(a_idx_zero_outside, clk_i, rst_ni, (hdr_q != HDR_COLLECT) |-> (wr_idx_q == '0))

endmodule

// ===== sv/hdcf_back.sv =====
`include "header_delimited_command_framer_assert.svh"

module hdcf_back
  import hdcf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         pop_valid_i,
  output logic         pop_ready_o,
  input  hdcf_entry_t  pop_entry_i,
  hdcf_out_if.source   tx_o
);

  localparam logic S_ECHO  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic             state_q, state_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q;
  logic             out_kind_q, out_last_q;
  logic [7:0]       cmd_mem [BUF_DEPTH];
  logic             out_free, pop, drain_step, drain_end;

  assign tx_o.valid    = out_valid_q;
  assign tx_o.out_byte = out_byte_q;
  assign tx_o.out_kind = out_kind_q;
  assign tx_o.out_last = out_last_q;

  // output register is free when empty or being taken
  assign out_free    = !out_valid_q || tx_o.ready;
  assign pop         = (state_q == S_ECHO) && pop_valid_i && out_free;
  assign pop_ready_o = (state_q == S_ECHO) && out_free;
  assign drain_step  = (state_q == S_DRAIN) && out_free;
  assign drain_end   = (rd_idx_q == last_q);

  // sequencer: echo, then drain the command on completion
  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    if (pop || drain_step) begin
      out_valid_d = 1'b1;
    end else if (tx_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop && pop_entry_i.done) begin
      state_d  = S_DRAIN;
      rd_idx_d = '0;
      last_d   = pop_entry_i.idx;
    end
    if (drain_step) begin
      rd_idx_d = rd_idx_q + IDX_W'(1);
      if (drain_end) begin
        state_d  = S_ECHO;
        rd_idx_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ECHO;
      rd_idx_q    <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // command buffer write and output word load (registered read)
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (pop_entry_i.store) begin
        cmd_mem[pop_entry_i.idx] <= pop_entry_i.data;
      end
      out_byte_q <= pop_entry_i.data;
      out_kind_q <= KIND_ECHO;
      out_last_q <= !pop_entry_i.done;
    end else if (drain_step) begin
      out_byte_q <= cmd_mem[rd_idx_q];
      out_kind_q <= KIND_CMD;
      out_last_q <= drain_end;
    end
  end

  `HDCF_ASSERT(a_drain_has_word, clk_i, rst_ni, (state_q == S_DRAIN) |-> out_valid_q)
  `HDCF_NEVER(a_drain_in_range, clk_i, rst_ni, (state_q == S_DRAIN) && (rd_idx_q > last_q))

endmodule
